>>> rtl/jhd_pkg.sv
package jhd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int N_STAGES   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd4;

    localparam logic [9:0]         AXIS_CENTRE = 10'd512;
    localparam logic [11:0]        AXIS_SPAN   = 12'd1023;
    localparam logic [11:0]        AXIS_SPAN2  = 12'd2046;
    localparam logic [15:0]        HEAD_WRAP   = 16'd36000;
    localparam logic signed [16:0] FULL_CIRCLE = 17'sd36000;
    localparam logic signed [16:0] HALF_CIRCLE = 17'sd18000;
    // floor(q/100) == (q * RECIP_100) >> 30 for q below Q_SAT
    localparam logic [23:0]        RECIP_100   = 24'd10737419;
    localparam logic [32:0]        Q_SAT       = 33'd6553600;
    localparam logic signed [17:0] DRIVE_MAX   = 18'sd32767;

    typedef struct packed {
        logic [8:0]  dz;
        logic [9:0]  max_drive;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
    } t_cfg;

    // ld[k]: stage k register takes new content; vld[k]: stage k holds a request
    typedef struct packed {
        logic [N_STAGES-1:0] ld;
        logic [N_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

>>> rtl/jhd_in_if.sv
interface jhd_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] stick_x;
    logic [9:0] stick_y;
    logic [15:0] measured_heading;

    modport source (output valid, output stick_x, output stick_y,
                    output measured_heading, input ready);
    modport sink   (input valid, input stick_x, input stick_y,
                    input measured_heading, output ready);
endinterface

>>> rtl/jhd_out_if.sv
interface jhd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel_left;
    logic signed [15:0] wheel_right;

    modport source (output valid, output wheel_left, output wheel_right, input ready);
    modport sink   (input valid, input wheel_left, input wheel_right, output ready);
endinterface

>>> rtl/joystick_heading_hold_drive_core.sv
// Channel   Dir  Handshake       Payload
// i_in      in   valid / ready   stick_x[9:0], stick_y[9:0], measured_heading[15:0]
// o_out     out  valid / ready   wheel_left[15:0] s, wheel_right[15:0] s
// i_cfg_*   in   i_cfg_wen       i_cfg_idx[2:0], i_cfg_data[15:0]
//
// One request per cycle sustained while o_out.ready is high; results leave from stage 8.
// The rate is set by the target/integral update, which jhd_hold closes combinationally.
// Reset (synchronous, active low) restores the register defaults and clears the state.
// Bubbles in the 9-stage pipe are squeezed out, so requests are taken while a result
// waits; i_in.ready only drops when every stage is full and o_out.ready is low.
module joystick_heading_hold_drive_core
    import jhd_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 8388607
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jhd_in_if.sink                i_in,
    jhd_out_if.source             o_out,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] ld;
    t_pipe_ctl           ctl;

    logic [9:0]  r_sx, r_sy;
    logic [15:0] r_head;

    logic signed [10:0] turn, fwd2, fwd3;
    logic [15:0]        head2;
    logic signed [15:0] err;
    logic signed [23:0] esum;
    logic signed [16:0] deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dz        <= 9'd15;
            r_cfg.max_drive <= 10'd255;
            r_cfg.gp        <= 16'd256;
            r_cfg.gi        <= 16'd256;
            r_cfg.gd        <= 16'd0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_DEADZONE:  r_cfg.dz        <= i_cfg_data[8:0];
                CFG_MAX_DRIVE: r_cfg.max_drive <= i_cfg_data[9:0];
                CFG_GAIN_P:    r_cfg.gp        <= i_cfg_data;
                CFG_GAIN_I:    r_cfg.gi        <= i_cfg_data;
                CFG_GAIN_D:    r_cfg.gd        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ld[N_STAGES-1] = !r_vld[N_STAGES-1] || o_out.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_sx   <= i_in.stick_x;
            r_sy   <= i_in.stick_y;
            r_head <= i_in.measured_heading;
        end
    end

    assign ctl.ld  = ld;
    assign ctl.vld = r_vld;

    assign i_in.ready  = ld[0];
    assign o_out.valid = r_vld[N_STAGES-1];

    jhd_axis u_axis (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_sx   (r_sx),
        .i_sy   (r_sy),
        .i_head (r_head),
        .o_turn (turn),
        .o_fwd  (fwd2),
        .o_head (head2)
    );

    jhd_hold #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_hold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_turn  (turn),
        .i_fwd   (fwd2),
        .i_head  (head2),
        .o_err   (err),
        .o_sum   (esum),
        .o_deriv (deriv),
        .o_fwd   (fwd3)
    );

    jhd_pid u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cfg   (r_cfg),
        .i_err   (err),
        .i_sum   (esum),
        .i_deriv (deriv),
        .i_fwd   (fwd3),
        .o_left  (o_out.wheel_left),
        .o_right (o_out.wheel_right)
    );

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output stage");

endmodule

>>> rtl/jhd_axis.sv
module jhd_axis
    import jhd_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  t_cfg               i_cfg,
    input  logic [9:0]         i_sx,
    input  logic [9:0]         i_sy,
    input  logic [15:0]        i_head,
    output logic signed [10:0] o_turn,
    output logic signed [10:0] o_fwd,
    output logic [15:0]        o_head
);

    function automatic logic in_deadzone(input logic [9:0] v, input logic [8:0] dz);
        logic [9:0] off;
        off = (v >= AXIS_CENTRE) ? (v - AXIS_CENTRE) : (AXIS_CENTRE - v);
        return (off < {1'b0, dz}) || (v == AXIS_CENTRE);
    endfunction

    // (2*p)/1023 - m, with /1023 as x/1024 plus a small remainder correction
    function automatic logic signed [10:0] axis_scale(input logic [19:0] p,
                                                      input logic [9:0] m);
        logic [20:0]        x;
        logic [10:0]        q0;
        logic [11:0]        rem;
        logic [10:0]        q;
        logic signed [11:0] a;
        x   = {p, 1'b0};
        q0  = x[20:10];
        rem = {2'b00, x[9:0]} + {1'b0, q0};
        if (rem >= AXIS_SPAN2) begin
            q = q0 + 11'd2;
        end else if (rem >= AXIS_SPAN) begin
            q = q0 + 11'd1;
        end else begin
            q = q0;
        end
        a = $signed({1'b0, q}) - $signed({2'b00, m});
        return a[10:0];
    endfunction

    logic [19:0] r_px, r_py;
    logic        r_zx, r_zy;
    logic [15:0] r_head1;
    logic signed [10:0] r_turn, r_fwd;
    logic [15:0] r_head2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_px    <= i_sx * i_cfg.max_drive;
            r_py    <= i_sy * i_cfg.max_drive;
            r_zx    <= in_deadzone(i_sx, i_cfg.dz);
            r_zy    <= in_deadzone(i_sy, i_cfg.dz);
            r_head1 <= (i_head >= HEAD_WRAP) ? (i_head - HEAD_WRAP) : i_head;
        end
        if (i_ctl.ld[2]) begin
            r_turn  <= r_zx ? 11'sd0 : axis_scale(r_px, i_cfg.max_drive);
            r_fwd   <= r_zy ? 11'sd0 : axis_scale(r_py, i_cfg.max_drive);
            r_head2 <= r_head1;
        end
    end

    assign o_turn = r_turn;
    assign o_fwd  = r_fwd;
    assign o_head = r_head2;

endmodule

>>> rtl/jhd_hold.sv
module jhd_hold
    import jhd_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 8388607
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  logic signed [10:0] i_turn,
    input  logic signed [10:0] i_fwd,
    input  logic [15:0]        i_head,
    output logic signed [15:0] o_err,
    output logic signed [23:0] o_sum,
    output logic signed [16:0] o_deriv,
    output logic signed [10:0] o_fwd
);

    localparam logic signed [24:0] LIM_POS = 25'(INTEGRAL_LIMIT);
    localparam logic signed [24:0] LIM_NEG = -LIM_POS;

    logic [15:0]        r_target;
    logic               r_loaded;
    logic signed [15:0] r_prev;
    logic signed [23:0] r_esum;

    logic signed [15:0] r_err;
    logic signed [23:0] r_sum;
    logic signed [16:0] r_deriv;
    logic signed [10:0] r_fwd;

    logic               upd;
    logic signed [16:0] base, head_s, t, t_w, err_raw, err_w;
    logic signed [13:0] step;
    logic signed [24:0] sum_raw, sum_c;
    logic [15:0]        n_target;
    logic signed [15:0] n_err;
    logic signed [23:0] n_sum;
    logic signed [16:0] n_deriv;

    assign upd = i_ctl.ld[3] && i_ctl.vld[2];

    always_comb begin
        head_s  = $signed({1'b0, i_head});
        base    = r_loaded ? $signed({1'b0, r_target}) : head_s;
        step    = $signed({i_turn[10], i_turn, 2'b00}) + $signed({{3{i_turn[10]}}, i_turn});
        t       = base + $signed({{3{step[13]}}, step});
        if (t > FULL_CIRCLE) begin
            t_w = t - FULL_CIRCLE;
        end else if (t < 17'sd0) begin
            t_w = t + FULL_CIRCLE;
        end else begin
            t_w = t;
        end
        n_target = t_w[15:0];
        err_raw  = t_w - head_s;
        if (err_raw > HALF_CIRCLE) begin
            err_w = err_raw - FULL_CIRCLE;
        end else if (err_raw < -HALF_CIRCLE) begin
            err_w = err_raw + FULL_CIRCLE;
        end else begin
            err_w = err_raw;
        end
        n_err   = err_w[15:0];
        sum_raw = $signed({r_esum[23], r_esum}) + $signed({{9{n_err[15]}}, n_err});
        if (sum_raw > LIM_POS) begin
            sum_c = LIM_POS;
        end else if (sum_raw < LIM_NEG) begin
            sum_c = LIM_NEG;
        end else begin
            sum_c = sum_raw;
        end
        n_sum   = sum_c[23:0];
        n_deriv = $signed({n_err[15], n_err}) - $signed({r_prev[15], r_prev});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_loaded <= 1'b0;
            r_prev   <= '0;
            r_esum   <= '0;
        end else if (upd) begin
            r_target <= n_target;
            r_loaded <= 1'b1;
            r_prev   <= n_err;
            r_esum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[3]) begin
            r_err   <= n_err;
            r_sum   <= n_sum;
            r_deriv <= n_deriv;
            r_fwd   <= i_fwd;
        end
    end

    assign o_err   = r_err;
    assign o_sum   = r_sum;
    assign o_deriv = r_deriv;
    assign o_fwd   = r_fwd;

    a_loaded_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> r_loaded)
        else $error("target not marked loaded after first request");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_target <= 16'd36000))
        else $error("held target out of range");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[3] |-> (r_err <= 16'sd18000 && r_err >= -16'sd18000))
        else $error("wrapped heading error out of range");

endmodule

>>> rtl/jhd_pid.sv
module jhd_pid
    import jhd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_err,
    input  logic signed [23:0] i_sum,
    input  logic signed [16:0] i_deriv,
    input  logic signed [10:0] i_fwd,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right
);

    logic signed [32:0] r_pp;
    logic signed [40:0] r_pi;
    logic signed [33:0] r_pd;
    logic signed [10:0] r_fwd4, r_fwd5, r_fwd6, r_fwd7;
    logic signed [41:0] r_tot;
    logic               r_neg6, r_neg7_unused_guard;
    logic               r_sat;
    logic [22:0]        r_q;
    logic signed [16:0] r_corr;
    logic signed [15:0] r_left, r_right;

    logic [41:0]        mag;
    logic [32:0]        q;
    logic [46:0]        prod;
    logic [15:0]        quot;
    logic signed [17:0] lsum, rsum;

    function automatic logic signed [15:0] sat_drive(input logic signed [17:0] v);
        logic signed [17:0] c;
        if (v > DRIVE_MAX) begin
            c = DRIVE_MAX;
        end else if (v < -DRIVE_MAX) begin
            c = -DRIVE_MAX;
        end else begin
            c = v;
        end
        return c[15:0];
    endfunction

    always_comb begin
        mag  = r_tot[41] ? (~r_tot + 42'd1) : r_tot;
        q    = mag[40:8];
        prod = r_q * RECIP_100;
        quot = r_sat ? 16'hFFFF : prod[45:30];
        lsum = $signed({{7{r_fwd7[10]}}, r_fwd7}) + $signed({r_corr[16], r_corr});
        rsum = $signed({{7{r_fwd7[10]}}, r_fwd7}) - $signed({r_corr[16], r_corr});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[4]) begin
            r_pp   <= $signed({1'b0, i_cfg.gp}) * i_err;
            r_pi   <= $signed({1'b0, i_cfg.gi}) * i_sum;
            r_pd   <= $signed({1'b0, i_cfg.gd}) * i_deriv;
            r_fwd4 <= i_fwd;
        end
        if (i_ctl.ld[5]) begin
            r_tot  <= $signed({{9{r_pp[32]}}, r_pp}) + $signed({r_pi[40], r_pi})
                    + $signed({{8{r_pd[33]}}, r_pd});
            r_fwd5 <= r_fwd4;
        end
        // truncation toward zero: work on the magnitude, /256 then /100
        if (i_ctl.ld[6]) begin
            r_neg6 <= r_tot[41];
            r_sat  <= (q >= Q_SAT);
            r_q    <= q[22:0];
            r_fwd6 <= r_fwd5;
        end
        if (i_ctl.ld[7]) begin
            r_corr <= r_neg6 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
            r_fwd7 <= r_fwd6;
            r_neg7_unused_guard <= r_neg6;
        end
        if (i_ctl.ld[8]) begin
            r_left  <= sat_drive(lsum);
            r_right <= sat_drive(rsum);
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[8] |-> (r_left != -16'sd32768 && r_right != -16'sd32768))
        else $error("drive outside saturation range");

    a_corr_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[7] |-> (r_neg7_unused_guard || !r_corr[16]))
        else $error("positive correction came out negative");

endmodule

>>> tb/joystick_heading_hold_drive_core_tb.sv
`timescale 1ns / 1ps

module joystick_heading_hold_drive_core_tb
    import jhd_pkg::*;
();

    localparam int FULL_TURN    = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int STICK_CENTRE = 512;
    localparam int STICK_SPAN   = 1023;
    localparam int TURN_STEP    = 5;
    localparam longint CORR_DIV = 25600;
    localparam longint CORR_LIM = 1000000;
    localparam longint DRIVE_LIM    = 32767;
    localparam longint INTEGRAL_LIM = 8388607;
    localparam int PIPE_LATENCY = 9;
    localparam int CYCLE_LIMIT  = 400000;

    // Predicts the wheel drives of each request and holds them until the pair comes out.
    class drive_tracker;
        typedef struct packed {
            logic signed [15:0] left;
            logic signed [15:0] right;
        } t_drive_pair;

        logic [8:0]  dz;
        logic [9:0]  md;
        logic [15:0] gp, gi, gd;

        int target;
        bit loaded;
        int prev_err;
        int err_sum;

        t_drive_pair pending_drives[$];
        int fail_cnt, req_cnt, res_cnt, sum_sat_cnt, clamp_cnt;

        function new();
            dz = 9'd15;
            md = 10'd255;
            gp = 16'd256;
            gi = 16'd256;
            gd = 16'd0;
            target = 0;
            loaded = 0;
            prev_err = 0;
            err_sum = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_DEADZONE:  dz = data[8:0];
                CFG_MAX_DRIVE: md = data[9:0];
                CFG_GAIN_P:    gp = data;
                CFG_GAIN_I:    gi = data;
                CFG_GAIN_D:    gd = data;
                default: ;
            endcase
        endfunction

        function int stick_level(logic [9:0] raw);
            int v, off;
            v = int'(raw);
            off = v - STICK_CENTRE;
            if (off < 0) off = -off;
            if (off < int'(dz) || v == STICK_CENTRE) return 0;
            return (v * 2 * int'(md)) / STICK_SPAN - int'(md);
        endfunction

        function longint clamp(longint x, longint lim);
            if (x > lim) return lim;
            if (x < -lim) return -lim;
            return x;
        endfunction

        function void take_request(logic [9:0] sx, logic [9:0] sy, logic [15:0] mh);
            int turn, fwd, head, err, deriv;
            longint sum, corr, left, right;
            t_drive_pair pair;
            turn = stick_level(sx);
            fwd  = stick_level(sy);
            head = int'(mh);
            if (head >= FULL_TURN) head -= FULL_TURN;
            if (!loaded) begin
                target = head;
                loaded = 1;
            end
            target += turn * TURN_STEP;
            if (target > FULL_TURN) target -= FULL_TURN;
            if (target < 0) target += FULL_TURN;
            err = target - head;
            if (err > HALF_TURN) err -= FULL_TURN;
            if (err < -HALF_TURN) err += FULL_TURN;
            sum = longint'(err_sum) + err;
            if (sum > INTEGRAL_LIM || sum < -INTEGRAL_LIM) sum_sat_cnt++;
            sum = clamp(sum, INTEGRAL_LIM);
            err_sum = int'(sum);
            deriv = err - prev_err;
            prev_err = err;
            corr = longint'(gp) * err + longint'(gi) * sum + longint'(gd) * deriv;
            corr = clamp(corr / CORR_DIV, CORR_LIM);
            left  = fwd + corr;
            right = fwd - corr;
            if (left != clamp(left, DRIVE_LIM) || right != clamp(right, DRIVE_LIM))
                clamp_cnt++;
            left  = clamp(left, DRIVE_LIM);
            right = clamp(right, DRIVE_LIM);
            pair.left  = left[15:0];
            pair.right = right[15:0];
            pending_drives.push_back(pair);
            req_cnt++;
        endfunction

        function void match_drive(logic signed [15:0] left, logic signed [15:0] right);
            t_drive_pair pair;
            if (pending_drives.size() == 0) begin
                $error("wheel_left: expected none, actual %0d (wheel_right %0d)", left, right);
                fail_cnt++;
                return;
            end
            pair = pending_drives.pop_front();
            res_cnt++;
            if (left !== pair.left) begin
                $error("wheel_left: expected %0d, actual %0d", pair.left, left);
                fail_cnt++;
            end
            if (right !== pair.right) begin
                $error("wheel_right: expected %0d, actual %0d", pair.right, right);
                fail_cnt++;
            end
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    jhd_in_if  in_if ();
    jhd_out_if out_if ();

    joystick_heading_hold_drive_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    drive_tracker track;
    bit calm = 0;
    int n_settings = 0;
    int cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sink side: random stall bursts until the calm tail
    initial begin : sink_stalls
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            track.match_drive(out_if.wheel_left, out_if.wheel_right);
    end

    task automatic send_request(logic [9:0] sx, logic [9:0] sy, logic [15:0] mh);
        in_if.valid            <= 1'b1;
        in_if.stick_x          <= sx;
        in_if.stick_y          <= sy;
        in_if.measured_heading <= mh;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        track.take_request(sx, sy, mh);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        in_if.valid <= 1'b0;
        while (track.pending() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic apply_setting(int dz, int md, int gp, int gi, int gd);
        logic [15:0] vals [5];
        logic [CFG_IDX_W-1:0] idxs [5];
        settle();
        vals = '{16'(dz), 16'(md), 16'(gp), 16'(gi), 16'(gd)};
        idxs = '{CFG_DEADZONE, CFG_MAX_DRIVE, CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D};
        for (int k = 0; k < 5; k++) begin
            cfg_wen  <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
            track.set_reg(idxs[k], vals[k]);
        end
        cfg_wen <= 1'b0;
        n_settings++;
    endtask

    // biased towards the rails and the deadzone edge
    function automatic logic [9:0] pick_stick();
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = $urandom_range(0, 1023);
            2: v = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(1020, 1023);
            default: begin
                v = STICK_CENTRE + int'(track.dz) - 2 + int'($urandom_range(0, 4));
                if ($urandom_range(0, 1)) v = 2 * STICK_CENTRE - v;
            end
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[9:0];
    endfunction

    function automatic logic [15:0] pick_heading();
        int r, h;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            h = int'($urandom_range(0, 4000)) - 2000 + track.target;
            while (h < 0) h += FULL_TURN;
            while (h >= FULL_TURN) h -= FULL_TURN;
        end else if (r < 17) begin
            h = $urandom_range(0, FULL_TURN - 1);
        end else begin
            h = $urandom_range(FULL_TURN, 65535);
        end
        return h[15:0];
    endfunction

    // heading just under half a turn ahead of the target keeps the error near -18000
    function automatic logic [15:0] windup_heading();
        int h;
        h = track.target + int'($urandom_range(17500, 18000));
        if (h >= FULL_TURN) h -= FULL_TURN;
        return h[15:0];
    endfunction

    initial begin : stimulus
        int n;
        track = new();
        in_if.valid            <= 1'b0;
        in_if.stick_x          <= '0;
        in_if.stick_y          <= '0;
        in_if.measured_heading <= '0;
        cfg_wen  <= 1'b0;
        cfg_idx  <= CFG_DEADZONE;
        cfg_data <= '0;
        i_rst_n  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: target capture, rails, deadzone edge, heading range
        send_request(10'd512, 10'd512, 16'd9000);
        send_request(10'd1023, 10'd1023, 16'd9000);
        send_request(10'd0, 10'd0, 16'd9000);
        send_request(10'd511, 10'd513, 16'd9000);
        send_request(10'd527, 10'd497, 16'd100);
        send_request(10'd526, 10'd498, 16'd100);
        send_request(10'd512, 10'd512, 16'd0);
        send_request(10'd512, 10'd512, 16'd35999);
        send_request(10'd512, 10'd512, 16'd36000);
        send_request(10'd512, 10'd512, 16'd65535);

        // full turn rate: target wraps both ways, error wraps both ways
        apply_setting(0, 1023, 65535, 0, 65535);
        send_request(10'd0, 10'd1023, 16'd100);
        send_request(10'd0, 10'd0, 16'd100);
        send_request(10'd512, 10'd512, 16'd100);
        send_request(10'd1023, 10'd512, 16'd35000);
        send_request(10'd1023, 10'd1023, 16'd35000);
        send_request(10'd513, 10'd511, 16'd20000);

        // zero drive range
        apply_setting(511, 0, 256, 256, 256);
        send_request(10'd0, 10'd1023, 16'd18000);
        send_request(10'd1023, 10'd0, 16'd0);

        // widest deadzone, smallest nonzero drive range
        apply_setting(511, 1, 0, 65535, 0);
        send_request(10'd0, 10'd1023, 16'd18000);
        send_request(10'd1023, 10'd0, 16'd0);
        send_request(10'd1, 10'd1022, 16'd30000);

        apply_setting($urandom_range(0, 40), $urandom_range(1, 1023), $urandom_range(0, 2048),
                      $urandom_range(0, 2048), $urandom_range(0, 2048));
        for (n = 0; n < 80; n++) begin
            if (n == 40) wait_results();
            send_request(pick_stick(), pick_stick(), pick_heading());
        end

        // drive the integral into its limit, then let it see noise
        apply_setting($urandom_range(0, 30), 1023, 65535, 65535, 65535);
        for (n = 0; n < 500; n++) begin
            if (n < 480) send_request(10'd512, pick_stick(), windup_heading());
            else send_request(pick_stick(), pick_stick(), pick_heading());
        end

        calm = 1;
        apply_setting($urandom_range(0, 100), $urandom_range(1, 1023), $urandom_range(0, 65535),
                      $urandom_range(0, 3), $urandom_range(0, 65535));
        for (n = 0; n < 60; n++) send_request(pick_stick(), pick_stick(), pick_heading());

        settle();
        $display("Ran %0d requests under %0d register settings, %0d drive pairs compared",
                 track.req_cnt, n_settings + 1, track.res_cnt);
        $display("Integral held at its limit on %0d requests, drives clamped on %0d",
                 track.sum_sat_cnt, track.clamp_cnt);
        if (track.fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
